// ===== rtl/sdbu_pkg.sv =====
// Shared types and constants of the spectral deconvolution bin unit.
package sdbu_pkg;

  localparam logic [1:0] MODE_SCAN   = 2'd0;
  localparam logic [1:0] MODE_INV    = 2'd1;
  localparam logic [1:0] MODE_WIENER = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAT      = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;

  localparam logic CFG_EPSILON = 1'b0;
  localparam logic CFG_NOISE   = 1'b1;

  localparam logic [15:0] EPS_RESET   = 16'd3277;
  localparam logic [31:0] NOISE_RESET = 32'd429497;

  localparam int EPS_FRAC   = 16;
  localparam int NOISE_FRAC = 32;
  localparam int CFG_BITS   = 32;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_MUL_HRHR,
    OP_MUL_HIHI,
    OP_MUL_GRL_HR,
    OP_MUL_GRH_HR,
    OP_MUL_GIL_HI,
    OP_MUL_GIH_HI,
    OP_MUL_GIL_HR,
    OP_MUL_GIH_HR,
    OP_MUL_GRL_HI,
    OP_MUL_GRH_HI,
    OP_MUL_EPS_S,
    OP_MUL_TL_TL,
    OP_MUL_TL_TH,
    OP_MUL_TH_TH,
    OP_WAIT,
    OP_CAP_PW,
    OP_CAP_NRE,
    OP_CAP_NIM,
    OP_CAP_T,
    OP_SCAN,
    OP_SQ_INIT,
    OP_SQ_STEP,
    OP_CMP,
    OP_DL_INV,
    OP_DL_FB,
    OP_DL_WIEN,
    OP_DIV,
    OP_FIN
  } dp_op_e;

  typedef enum logic [1:0] {
    SH_0,
    SH_CH,
    SH_TH,
    SH_2TH
  } sh_e;

  typedef struct packed {
    dp_op_e op;
    logic   load;
  } dp_cmd_t;

  typedef struct packed {
    logic pass;
  } dp_stat_t;

endpackage

// ===== rtl/sdbu_ctrl.sv =====
// Sequencer of the bin unit: steps the datapath through one bin.
module sdbu_ctrl #(
  parameter int FILTER_BITS = 24,
  parameter int DIV_STEPS   = 43
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdbu_pkg::dp_cmd_t cmd_o,
  input  sdbu_pkg::dp_stat_t stat_i
);
  import sdbu_pkg::*;

  localparam int MAXC = (FILTER_BITS > DIV_STEPS) ? FILTER_BITS : DIV_STEPS;
  localparam int CW   = $clog2(MAXC + 1);

  typedef enum logic [5:0] {
    S_IDLE, S_PW1, S_PW2, S_PW_W, S_PW_C, S_SCAN,
    S_RE1, S_RE2, S_RE3, S_RE4, S_RE_W, S_RE_C,
    S_IM1, S_IM2, S_IM3, S_IM4, S_IM_W, S_IM_C,
    S_WDEN, S_SQI, S_SQ, S_EPS, S_T_W, S_T_C,
    S_TT1, S_TT2, S_TT3, S_TT4, S_TT_W, S_CMP,
    S_DLI, S_DLF, S_DIV, S_FIN
  } state_e;

  state_e         state_q, state_d;
  logic [1:0]     mode_q;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic           accept, out_free;
  dp_op_e         op;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = op;
  assign cmd_o.load  = accept;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: if (accept && mode_i != MODE_NONE) state_d = S_PW1;
      S_PW1:  state_d = S_PW2;
      S_PW2:  state_d = S_PW_W;
      S_PW_W: state_d = S_PW_C;
      S_PW_C: state_d = (mode_q == MODE_SCAN) ? S_SCAN : S_RE1;
      S_SCAN: state_d = S_IDLE;
      S_RE1:  state_d = S_RE2;
      S_RE2:  state_d = S_RE3;
      S_RE3:  state_d = S_RE4;
      S_RE4:  state_d = S_RE_W;
      S_RE_W: state_d = S_RE_C;
      S_RE_C: state_d = S_IM1;
      S_IM1:  state_d = S_IM2;
      S_IM2:  state_d = S_IM3;
      S_IM3:  state_d = S_IM4;
      S_IM4:  state_d = S_IM_W;
      S_IM_W: state_d = S_IM_C;
      S_IM_C: state_d = (mode_q == MODE_INV) ? S_SQI : S_WDEN;
      S_WDEN: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_SQI: begin
        state_d = S_SQ;
        cnt_d   = '0;
      end
      S_SQ: begin
        if (cnt_q == CW'(FILTER_BITS - 1)) state_d = S_EPS;
        else cnt_d = cnt_q + 1'b1;
      end
      S_EPS:  state_d = S_T_W;
      S_T_W:  state_d = S_T_C;
      S_T_C:  state_d = S_TT1;
      S_TT1:  state_d = S_TT2;
      S_TT2:  state_d = S_TT3;
      S_TT3:  state_d = S_TT4;
      S_TT4:  state_d = S_TT_W;
      S_TT_W: state_d = S_CMP;
      S_CMP:  state_d = stat_i.pass ? S_DLI : S_DLF;
      S_DLI, S_DLF: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        if (cnt_q == CW'(DIV_STEPS - 1)) state_d = S_FIN;
        else cnt_d = cnt_q + 1'b1;
      end
      S_FIN: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_PW1:  op = OP_MUL_HRHR;
      S_PW2:  op = OP_MUL_HIHI;
      S_PW_C: op = OP_CAP_PW;
      S_SCAN: op = OP_SCAN;
      S_RE1:  op = OP_MUL_GRL_HR;
      S_RE2:  op = OP_MUL_GRH_HR;
      S_RE3:  op = OP_MUL_GIL_HI;
      S_RE4:  op = OP_MUL_GIH_HI;
      S_RE_C: op = OP_CAP_NRE;
      S_IM1:  op = OP_MUL_GIL_HR;
      S_IM2:  op = OP_MUL_GIH_HR;
      S_IM3:  op = OP_MUL_GRL_HI;
      S_IM4:  op = OP_MUL_GRH_HI;
      S_IM_C: op = OP_CAP_NIM;
      S_WDEN: op = OP_DL_WIEN;
      S_SQI:  op = OP_SQ_INIT;
      S_SQ:   op = OP_SQ_STEP;
      S_EPS:  op = OP_MUL_EPS_S;
      S_T_C:  op = OP_CAP_T;
      S_TT1:  op = OP_MUL_TL_TL;
      S_TT2:  op = OP_MUL_TL_TH;
      S_TT3:  op = OP_MUL_TL_TH;
      S_TT4:  op = OP_MUL_TH_TH;
      S_CMP:  op = OP_CMP;
      S_DLI:  op = OP_DL_INV;
      S_DLF:  op = OP_DL_FB;
      S_DIV:  op = OP_DIV;
      S_FIN:  op = out_free ? OP_FIN : OP_WAIT;
      S_PW_W, S_RE_W, S_IM_W, S_T_W, S_TT_W: op = OP_WAIT;
      default: op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_SCAN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (accept) mode_q <= mode_i;
    end
  end

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i != MODE_NONE) |=> (state_q == S_PW1))
    else $error("accepted transaction did not start the sequence");

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < CW'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_sqrt_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQ) |-> (cnt_q < CW'(FILTER_BITS)))
    else $error("root step count out of range");

  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside the finish step");

endmodule

// ===== rtl/sdbu_dp.sv =====
// Datapath of the bin unit: shared multiplier, root unit and two dividers.
module sdbu_dp #(
  parameter int FILTER_BITS   = 24,
  parameter int SPECTRUM_BITS = 40,
  parameter int NUM_BITS      = 86
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sdbu_pkg::dp_cmd_t               cmd_i,
  output sdbu_pkg::dp_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [sdbu_pkg::CFG_BITS-1:0]   cfg_data_i,
  input  logic                            restart_i,
  input  logic signed [FILTER_BITS-1:0]   filter_re_i,
  input  logic signed [FILTER_BITS-1:0]   filter_im_i,
  input  logic signed [SPECTRUM_BITS-1:0] image_re_i,
  input  logic signed [SPECTRUM_BITS-1:0] image_im_i,
  output logic signed [SPECTRUM_BITS-1:0] restored_re_o,
  output logic signed [SPECTRUM_BITS-1:0] restored_im_o,
  output logic                            clamped_gain_o,
  output logic [1:0]                      status_o
);
  import sdbu_pkg::*;

  localparam int F    = FILTER_BITS;
  localparam int S    = SPECTRUM_BITS;
  localparam int CH   = (S + 1) / 2;
  localparam int TW   = F + EPS_FRAC;
  localparam int TH   = (TW + 1) / 2;
  localparam int MA0  = (F > CH) ? F : CH;
  localparam int MA   = (MA0 > TH) ? MA0 : TH;
  localparam int MB0  = (F > EPS_FRAC) ? F : EPS_FRAC;
  localparam int MB   = (MB0 > TH) ? MB0 : TH;
  localparam int PRW  = MA + MB;
  localparam int NRW  = S + F + 1;
  localparam int AW0  = (2 * TW > S + F) ? 2 * TW : S + F;
  localparam int AW   = AW0 + 1;
  localparam int DW   = (2 * F + 1 > TW) ? 2 * F + 1 : TW;
  localparam int NSH  = 2 * (F - 2) - NOISE_FRAC;
  localparam int NSHL = (NSH > 0) ? NSH : 0;
  localparam int NSHR = (NSH < 0) ? -NSH : 0;
  localparam int NZW  = NOISE_FRAC + NSHL;
  localparam int SH_NUM = F - 2;
  localparam int SH_FB  = EPS_FRAC + F - 2;
  localparam logic [S-1:0] LIM_POS = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0] LIM_NEG = {1'b1, {(S-1){1'b0}}};

  // Input magnitudes and signs of the current bin.
  logic [F-1:0]  hr_q, hi_q;
  logic [S-1:0]  gr_q, gi_q;
  logic          shr_q, shi_q, sgr_q, sgi_q, restart_q;
  // Configuration and state.
  logic [15:0]   eps_q;
  logic [31:0]   noise_q;
  logic [2*F-1:0] peak_q, pw_q;
  // Multiply-accumulate.
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic          p_v, p_neg;
  sh_e           p_sh;
  logic [PRW-1:0] prod_q;
  logic          pend_v_q, pend_neg_q;
  sh_e           pend_sh_q;
  logic [AW-1:0] acc_q, acc_d, term;
  logic [NRW-1:0] nre_q, nim_q;
  logic [TW-1:0] t_q;
  // Square root.
  logic [F-1:0]  root_q;
  logic [F:0]    sqr_q;
  logic [2*F-1:0] sqx_q;
  logic [F+2:0]  sq_rem2, sq_trial;
  // Dividers.
  logic [NUM_BITS-1:0] dn_re_q, dn_im_q;
  logic [DW-1:0] dr_re_q, dr_im_q, den_q;
  logic [S-1:0]  q_re_q, q_im_q;
  logic          ov_re_q, ov_im_q, neg_re_q, neg_im_q, zden_q, clamp_q;
  logic [DW:0]   st_re1, st_re2, st_im1, st_im2;
  // Result register.
  logic [S-1:0]  rre_q, rim_q;
  logic          clamped_q;
  logic [1:0]    status_q;

  logic [NZW-1:0] nz_full;
  logic [DW-1:0] nz, den_w;
  logic [NRW-2:0] mag_re, mag_im;
  logic [S:0]    fin_re, fin_im;
  logic [2*F-1:0] peak_base;

  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                           input logic nbit,
                                           input logic [DW-1:0] d);
    logic [DW:0] r2;
    r2 = {rem, nbit};
    if (r2 >= {1'b0, d}) return {1'b1, DW'(r2 - {1'b0, d})};
    else return {1'b0, r2[DW-1:0]};
  endfunction

  function automatic logic [S:0] finish(input logic [S-1:0] q, input logic ov,
                                        input logic neg);
    logic [S-1:0] lim, v;
    logic         sat;
    lim = neg ? LIM_NEG : LIM_POS;
    sat = ov || (q > lim);
    v   = sat ? lim : q;
    return {sat, neg ? (~v + 1'b1) : v};
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    p_v   = 1'b1;
    p_neg = 1'b0;
    p_sh  = SH_0;
    unique case (cmd_i.op)
      OP_MUL_HRHR: begin mul_a = MA'(hr_q); mul_b = MB'(hr_q); end
      OP_MUL_HIHI: begin mul_a = MA'(hi_q); mul_b = MB'(hi_q); end
      OP_MUL_GRL_HR: begin
        mul_a = MA'(gr_q[CH-1:0]); mul_b = MB'(hr_q); p_neg = sgr_q ^ shr_q;
      end
      OP_MUL_GRH_HR: begin
        mul_a = MA'(gr_q[S-1:CH]); mul_b = MB'(hr_q); p_neg = sgr_q ^ shr_q;
        p_sh = SH_CH;
      end
      OP_MUL_GIL_HI: begin
        mul_a = MA'(gi_q[CH-1:0]); mul_b = MB'(hi_q); p_neg = sgi_q ^ shi_q;
      end
      OP_MUL_GIH_HI: begin
        mul_a = MA'(gi_q[S-1:CH]); mul_b = MB'(hi_q); p_neg = sgi_q ^ shi_q;
        p_sh = SH_CH;
      end
      OP_MUL_GIL_HR: begin
        mul_a = MA'(gi_q[CH-1:0]); mul_b = MB'(hr_q); p_neg = sgi_q ^ shr_q;
      end
      OP_MUL_GIH_HR: begin
        mul_a = MA'(gi_q[S-1:CH]); mul_b = MB'(hr_q); p_neg = sgi_q ^ shr_q;
        p_sh = SH_CH;
      end
      OP_MUL_GRL_HI: begin
        mul_a = MA'(gr_q[CH-1:0]); mul_b = MB'(hi_q); p_neg = ~(sgr_q ^ shi_q);
      end
      OP_MUL_GRH_HI: begin
        mul_a = MA'(gr_q[S-1:CH]); mul_b = MB'(hi_q); p_neg = ~(sgr_q ^ shi_q);
        p_sh = SH_CH;
      end
      OP_MUL_EPS_S: begin mul_a = MA'(root_q); mul_b = MB'(eps_q); end
      OP_MUL_TL_TL: begin mul_a = MA'(t_q[TH-1:0]); mul_b = MB'(t_q[TH-1:0]); end
      OP_MUL_TL_TH: begin
        mul_a = MA'(t_q[TH-1:0]); mul_b = MB'(t_q[TW-1:TH]); p_sh = SH_TH;
      end
      OP_MUL_TH_TH: begin
        mul_a = MA'(t_q[TW-1:TH]); mul_b = MB'(t_q[TW-1:TH]); p_sh = SH_2TH;
      end
      default: p_v = 1'b0;
    endcase
  end

  always_comb begin
    unique case (pend_sh_q)
      SH_CH:   term = AW'(prod_q) << CH;
      SH_TH:   term = AW'(prod_q) << TH;
      SH_2TH:  term = AW'(prod_q) << (2 * TH);
      default: term = AW'(prod_q);
    endcase
    if (cmd_i.load || cmd_i.op == OP_CAP_PW || cmd_i.op == OP_CAP_NRE ||
        cmd_i.op == OP_CAP_NIM || cmd_i.op == OP_CAP_T) begin
      acc_d = '0;
    end else if (pend_v_q) begin
      acc_d = pend_neg_q ? (acc_q - term) : (acc_q + term);
    end else begin
      acc_d = acc_q;
    end
  end

  assign stat_o.pass = {pw_q, {NOISE_FRAC{1'b0}}} > acc_q[2*TW-1:0];

  assign sq_rem2  = {sqr_q, sqx_q[2*F-1:2*F-2]};
  assign sq_trial = (F+3)'({root_q, 2'b01});

  assign nz_full = (NZW'(noise_q) << NSHL) >> NSHR;
  assign nz      = DW'(nz_full);
  assign den_w   = DW'(pw_q) + nz;
  assign mag_re  = nre_q[NRW-1] ? (~nre_q[NRW-2:0] + 1'b1) : nre_q[NRW-2:0];
  assign mag_im  = nim_q[NRW-1] ? (~nim_q[NRW-2:0] + 1'b1) : nim_q[NRW-2:0];
  assign peak_base = restart_q ? '0 : peak_q;

  assign st_re1 = div_step(dr_re_q, dn_re_q[NUM_BITS-1], den_q);
  assign st_re2 = div_step(st_re1[DW-1:0], dn_re_q[NUM_BITS-2], den_q);
  assign st_im1 = div_step(dr_im_q, dn_im_q[NUM_BITS-1], den_q);
  assign st_im2 = div_step(st_im1[DW-1:0], dn_im_q[NUM_BITS-2], den_q);

  assign fin_re = finish(q_re_q, ov_re_q, neg_re_q);
  assign fin_im = finish(q_im_q, ov_im_q, neg_im_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q    <= EPS_RESET;
      noise_q  <= NOISE_RESET;
      peak_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      pend_v_q <= p_v;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_EPSILON) eps_q <= cfg_data_i[15:0];
        else noise_q <= cfg_data_i[31:0];
      end
      if (cmd_i.op == OP_SCAN) peak_q <= (pw_q > peak_base) ? pw_q : peak_base;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= mul_a * mul_b;
    pend_neg_q <= p_neg;
    pend_sh_q  <= p_sh;
    acc_q      <= acc_d;
    if (cmd_i.load) begin
      restart_q <= restart_i;
      shr_q <= filter_re_i[F-1];
      shi_q <= filter_im_i[F-1];
      sgr_q <= image_re_i[S-1];
      sgi_q <= image_im_i[S-1];
      hr_q  <= filter_re_i[F-1] ? -filter_re_i : filter_re_i;
      hi_q  <= filter_im_i[F-1] ? -filter_im_i : filter_im_i;
      gr_q  <= image_re_i[S-1] ? -image_re_i : image_re_i;
      gi_q  <= image_im_i[S-1] ? -image_im_i : image_im_i;
    end
    unique case (cmd_i.op)
      OP_CAP_PW:  pw_q  <= acc_q[2*F-1:0];
      OP_CAP_NRE: nre_q <= acc_q[NRW-1:0];
      OP_CAP_NIM: nim_q <= acc_q[NRW-1:0];
      OP_CAP_T:   t_q   <= acc_q[TW-1:0];
      OP_SQ_INIT: begin
        sqr_q  <= '0;
        root_q <= '0;
        sqx_q  <= peak_q;
      end
      OP_SQ_STEP: begin
        if (sq_rem2 >= sq_trial) begin
          sqr_q  <= (F+1)'(sq_rem2 - sq_trial);
          root_q <= {root_q[F-2:0], 1'b1};
        end else begin
          sqr_q  <= sq_rem2[F:0];
          root_q <= {root_q[F-2:0], 1'b0};
        end
        sqx_q <= sqx_q << 2;
      end
      OP_DL_INV, OP_DL_FB, OP_DL_WIEN: begin
        dr_re_q <= '0;
        dr_im_q <= '0;
        q_re_q  <= '0;
        q_im_q  <= '0;
        ov_re_q <= 1'b0;
        ov_im_q <= 1'b0;
        if (cmd_i.op == OP_DL_FB) begin
          dn_re_q  <= NUM_BITS'(gr_q) << SH_FB;
          dn_im_q  <= NUM_BITS'(gi_q) << SH_FB;
          neg_re_q <= sgr_q;
          neg_im_q <= sgi_q;
          den_q    <= DW'(t_q);
          zden_q   <= (t_q == '0);
          clamp_q  <= 1'b1;
        end else begin
          dn_re_q  <= NUM_BITS'(mag_re) << SH_NUM;
          dn_im_q  <= NUM_BITS'(mag_im) << SH_NUM;
          neg_re_q <= nre_q[NRW-1];
          neg_im_q <= nim_q[NRW-1];
          clamp_q  <= 1'b0;
          if (cmd_i.op == OP_DL_WIEN) begin
            den_q  <= den_w;
            zden_q <= (den_w == '0);
          end else begin
            den_q  <= DW'(pw_q);
            zden_q <= (pw_q == '0);
          end
        end
      end
      OP_DIV: begin
        dn_re_q <= dn_re_q << 2;
        dn_im_q <= dn_im_q << 2;
        dr_re_q <= st_re2[DW-1:0];
        dr_im_q <= st_im2[DW-1:0];
        // Quotient bits shifted beyond the output width mark overflow.
        q_re_q  <= {q_re_q[S-3:0], st_re1[DW], st_re2[DW]};
        q_im_q  <= {q_im_q[S-3:0], st_im1[DW], st_im2[DW]};
        ov_re_q <= ov_re_q | (|q_re_q[S-1:S-2]);
        ov_im_q <= ov_im_q | (|q_im_q[S-1:S-2]);
      end
      OP_FIN: begin
        clamped_q <= clamp_q;
        if (zden_q) begin
          rre_q    <= '0;
          rim_q    <= '0;
          status_q <= ST_ZERO_DEN;
        end else begin
          rre_q    <= fin_re[S-1:0];
          rim_q    <= fin_im[S-1:0];
          status_q <= (fin_re[S] || fin_im[S]) ? ST_SAT : ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign restored_re_o  = rre_q;
  assign restored_im_o  = rim_q;
  assign clamped_gain_o = clamped_q;
  assign status_o       = status_q;

endmodule

// ===== rtl/spectral_deconvolution_bin_unit.sv =====
// Top level of the per-bin inverse and Wiener deconvolution unit.
// Throughput: one bin at a time; the two-bit-per-cycle long divider and the one-bit-
// per-cycle square root set the pace. A result waits in the output register while
// the next bin is accepted. Reset clears the filter peak and loads the default
// epsilon and noise registers; no clearing pass is needed.
module spectral_deconvolution_bin_unit #(
  parameter int FILTER_BITS   = 24,
  parameter int SPECTRUM_BITS = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [sdbu_pkg::CFG_BITS-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      mode_i,
  input  logic                            restart_i,
  input  logic signed [FILTER_BITS-1:0]   filter_re_i,
  input  logic signed [FILTER_BITS-1:0]   filter_im_i,
  input  logic signed [SPECTRUM_BITS-1:0] image_re_i,
  input  logic signed [SPECTRUM_BITS-1:0] image_im_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SPECTRUM_BITS-1:0] restored_re_o,
  output logic signed [SPECTRUM_BITS-1:0] restored_im_o,
  output logic                            clamped_gain_o,
  output logic [1:0]                      status_o
);
  import sdbu_pkg::*;

  localparam int NW0 = SPECTRUM_BITS + 2 * FILTER_BITS - 2;
  localparam int NW1 = SPECTRUM_BITS + FILTER_BITS + EPS_FRAC - 2;
  localparam int NW  = (NW0 > NW1) ? NW0 : NW1;
  localparam int NUM_BITS  = NW + (NW % 2);
  localparam int DIV_STEPS = NUM_BITS / 2;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdbu_ctrl #(
    .FILTER_BITS(FILTER_BITS),
    .DIV_STEPS  (DIV_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  sdbu_dp #(
    .FILTER_BITS  (FILTER_BITS),
    .SPECTRUM_BITS(SPECTRUM_BITS),
    .NUM_BITS     (NUM_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .restart_i     (restart_i),
    .filter_re_i   (filter_re_i),
    .filter_im_i   (filter_im_i),
    .image_re_i    (image_re_i),
    .image_im_i    (image_im_i),
    .restored_re_o (restored_re_o),
    .restored_im_o (restored_im_o),
    .clamped_gain_o(clamped_gain_o),
    .status_o      (status_o)
  );

endmodule
